// ===== design/dcnt_pkg.sv =====
`default_nettype none

package dcnt_pkg;

   // Field widths of the request and response
   localparam int NUMBER_W = 16;
   localparam int COUNT_W  = 8;

   // Bits of the request value that take part in the count
   localparam int VALUE_WIDTH = 16;

   // Trial divisor: holds floor(sqrt(2^VALUE_WIDTH - 1)) + 1, the first failing divisor
   localparam int DIV_W   = (VALUE_WIDTH + 1) / 2 + 1;
   // Running square of the trial divisor
   localparam int SQ_W    = 2 * DIV_W;
   // Number of divisors found below the square root
   localparam int HIT_W   = DIV_W + 1;
   // Doubled count before saturation
   localparam int TOT_W   = HIT_W + 1;
   // Bit counter of the serial remainder unit
   localparam int BITS_W  = $clog2(VALUE_WIDTH + 1);

   localparam int COUNT_MAX = (1 << COUNT_W) - 1;

   typedef logic [NUMBER_W-1:0]    number_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [DIV_W-1:0]       div_type;

   // Status of the serial remainder unit
   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } rem_stat_type;

   // Keep the low VALUE_WIDTH bits of a request number, zero-extended if needed
   function automatic value_type to_value(input number_type x);
      logic [NUMBER_W+VALUE_WIDTH-1:0] wide;
      wide = {{VALUE_WIDTH{1'b0}}, x};
      return wide[VALUE_WIDTH-1:0];
   endfunction

   // Clamp the doubled count to the response field
   function automatic count_type sat_count(input logic [TOT_W-1:0] total);
      logic [TOT_W+COUNT_W-1:0] wide;
      wide = (TOT_W + COUNT_W)'(total);
      if (wide > (TOT_W + COUNT_W)'(COUNT_MAX)) begin
         return count_type'(COUNT_MAX);
      end
      return wide[COUNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/dcnt_if.sv =====
`default_nettype none

// Request channel: one number to be examined
interface dcnt_req_if
   import dcnt_pkg::*;
();
   logic       valid;
   logic       ready;
   number_type number;

   modport source (output valid, output number, input ready);
   modport sink (input valid, input number, output ready);
endinterface

// Response channel: the divisor count of one request
interface dcnt_rsp_if
   import dcnt_pkg::*;
();
   logic      valid;
   logic      ready;
   count_type divisor_count;

   modport source (output valid, output divisor_count, input ready);
   modport sink (input valid, input divisor_count, output ready);
endinterface

`default_nettype wire

// ===== design/divisor_count_trial_division_top.sv =====
// Divisor counter by trial division. Each request carries a 16-bit unsigned
// number; the response carries how many positive divisors it has (zero for
// zero, at most 255). Requests are handled one at a time. Trial divisors d
// run from 1 while d*d <= number; each takes a bound check in ST_CHECK plus
// a bit-serial remainder in the serial remainder unit. A finished count
// waits in an output register, so the next request is taken while the
// previous response is still waiting.
`default_nettype none

module divisor_count_trial_division_top
   import dcnt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   dcnt_req_if.sink    req_chan,
   dcnt_rsp_if.source  rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   value_type         value_ff, value_in;
   div_type           d_ff, d_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [HIT_W-1:0]  hits_ff, hits_in;
   logic              square_ff, square_in;
   logic              rsp_valid_ff, rsp_valid_in;
   count_type         rsp_count_ff, rsp_count_in;

   logic              fits;
   logic              rem_start;
   logic [TOT_W-1:0]  total;
   rem_stat_type      rem_stat;

   // Trial divisor still within the square-root bound
   assign fits      = (sq_ff <= SQ_W'(value_ff));
   assign rem_start = (state_ff == ST_CHECK) && fits;
   assign total     = {hits_ff, 1'b0} - TOT_W'(square_ff);

   dcnt_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .numerator (value_ff),
      .divisor   (d_ff),
      .stat      (rem_stat)
   );

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      d_in         = d_ff;
      sq_in        = sq_ff;
      hits_in      = hits_ff;
      square_in    = square_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Take a request and start at divisor one
            if (req_chan.valid) begin
               value_in  = to_value(req_chan.number);
               d_in      = DIV_W'(1);
               sq_in     = SQ_W'(1);
               hits_in   = '0;
               square_in = 1'b0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Divide while d*d fits, note the perfect square
            if (fits) begin
               if (sq_ff == SQ_W'(value_ff)) begin
                  square_in = 1'b1;
               end
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            // Count a hit, advance d and its square
            if (rem_stat.done) begin
               if (rem_stat.zero) begin
                  hits_in = hits_ff + 1'b1;
               end
               d_in     = d_ff + 1'b1;
               sq_in    = sq_ff + SQ_W'({d_ff, 1'b1});
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            // Load the response once the output register is free
            if (!(rsp_valid_ff && !rsp_chan.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = sat_count(total);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      hits_ff      <= hits_in;
      square_ff    <= square_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.divisor_count = rsp_count_ff;

   // The remainder unit is working whenever a division is awaited
   a_divide_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_stat.busy || rem_stat.done))
      else $error("waiting on an idle remainder unit");

   // The running square tracks the trial divisor
   a_square_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (sq_ff == SQ_W'(d_ff) * SQ_W'(d_ff)))
      else $error("running square out of step with divisor");

   // A trial divisor is never zero
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_DIVIDE) |-> (d_ff != '0))
      else $error("zero trial divisor");

   // Finishing with a free output register yields a response
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !(rsp_valid_ff && !rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("finished count not loaded");

endmodule

`default_nettype wire

// ===== design/dcnt_rem.sv =====
`default_nettype none

// Bit-serial restoring remainder: one numerator bit per cycle, MSB first
module dcnt_rem
   import dcnt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire value_type    numerator,
   input  wire div_type      divisor,
   output rem_stat_type      stat
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   value_type         shift_ff, shift_in;
   div_type           rem_ff, rem_in;
   div_type           div_ff, div_in;

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;

   // Shift in the next numerator bit and try the subtraction
   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         bits_in  = BITS_W'(VALUE_WIDTH);
         shift_in = numerator;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         // Restore when the trial value is below the divisor
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIV_W-1:0];
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         bits_in  = bits_ff - 1'b1;
         if (bits_ff == BITS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bits_ff <= bits_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.zero = (rem_ff == '0);

   // A new division never starts over a running one
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit started while busy");

   // Completion follows a busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a division");

   // Bits remain while the unit is busy
   a_bits_left: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (bits_ff != '0))
      else $error("remainder unit busy with no bits left");

endmodule

`default_nettype wire

// ===== sim/divisor_count_trial_division_top_tb.sv =====
`timescale 1ns / 100ps

module divisor_count_trial_division_top_tb
   import dcnt_pkg::*;
();

   logic clock;
   logic reset;

   dcnt_req_if req_chan ();
   dcnt_rsp_if rsp_chan ();

   divisor_count_trial_division_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Counts still owed by the block, oldest first
   count_type pending_counts[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int sent_count;
   int checked_count;
   int highest_count;
   int square_count;

   // Free-running clock, 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Trial division up to the integer square root; doubled, less one for a square
   function automatic count_type predict_divisor_count(input number_type value);
      int unsigned n;
      int unsigned trial;
      int unsigned last;
      int unsigned hits;
      int unsigned total;
      n = to_value(value);
      last = 0;
      hits = 0;
      if (n == 0) begin
         return '0;
      end
      for (trial = 1; trial * trial <= n; trial++) begin
         if (n % trial == 0) begin
            hits++;
         end
         last = trial;
      end
      total = hits * 2;
      if (last * last == n) begin
         total--;
      end
      if (total > COUNT_MAX) begin
         total = COUNT_MAX;
      end
      return count_type'(total);
   endfunction

   // Present one request, wait for it to be taken and record its count
   task automatic send_number(input number_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.number <= value;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      pending_counts.push_back(predict_divisor_count(value));
      if (predict_divisor_count(value) * predict_divisor_count(value) ==
          predict_divisor_count(value) * predict_divisor_count(value) &&
          int'(predict_divisor_count(value)) % 2 == 1) begin
         square_count++;
      end
      sent_count++;
   endtask

   // Zero, one, small primes, the ends of the 16-bit range, bit patterns and highly composite values
   task automatic test_edge_values();
      send_number(16'd0);
      send_number(16'd1);
      send_number(16'd2);
      send_number(16'd3);
      send_number(16'd65535);
      send_number(16'd65534);
      send_number(16'd65521);
      send_number(16'h8000);
      send_number(16'h7FFF);
      send_number(16'h5555);
      send_number(16'hAAAA);
      send_number(16'd55440);
      send_number(16'd45360);
   endtask

   // Perfect squares and near neighbours; in a square the last trial divisor is its own partner
   task automatic test_perfect_squares();
      send_number(16'd4);
      send_number(16'd9);
      send_number(16'd36);
      send_number(16'd3600);
      send_number(16'd65025);
      send_number(16'd65024);
      send_number(16'd64516);
      send_number(16'd49);
      send_number(16'd3599);
      send_number(16'd3601);
   endtask

   // Mix of full-range, small, square and highly composite values
   function automatic number_type pick_number();
      int unsigned root;
      int unsigned product;
      int unsigned factor;
      case ($urandom_range(4))
         0, 1: begin
            return number_type'($urandom_range(65535));
         end
         2: begin
            return number_type'($urandom_range(255));
         end
         3: begin
            root = $urandom_range(255);
            return number_type'(root * root);
         end
         default: begin
            product = 1;
            repeat (10) begin
               case ($urandom_range(5))
                  0: factor = 2;
                  1: factor = 3;
                  2: factor = 5;
                  3: factor = 7;
                  4: factor = 11;
                  default: factor = 13;
               endcase
               if (product * factor <= 65535) begin
                  product = product * factor;
               end
            end
            return number_type'(product);
         end
      endcase
   endfunction

   task automatic test_random_numbers(input int item_total);
      repeat (item_total) begin
         send_number(pick_number());
      end
   endtask

   // Randomly hold off the response channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response with the oldest expected count
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual count %0d",
                     $time, rsp_chan.divisor_count);
            error_count++;
         end else begin
            if (rsp_chan.divisor_count !== pending_counts[0]) begin
               $display("%0t: divisor_count differs, expected %0d, actual %0d",
                        $time, pending_counts[0], rsp_chan.divisor_count);
               error_count++;
            end
            if (int'(pending_counts[0]) > highest_count) begin
               highest_count = pending_counts[0];
            end
            void'(pending_counts.pop_front());
            checked_count++;
         end
      end
   end

   // Run the tests in turn
   initial begin
      error_count     = 0;
      sent_count      = 0;
      checked_count   = 0;
      highest_count   = 0;
      square_count    = 0;
      send_idle_pct   = 31;
      recv_idle_pct   = 83;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.number = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_edge_values();
      test_perfect_squares();
      test_random_numbers(36);

      send_idle_pct = 83;
      recv_idle_pct = 31;
      test_random_numbers(36);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_numbers(35);

      req_chan.valid <= 1'b0;
      wait (pending_counts.size() == 0);
      repeat (50) @(posedge clock);

      $display("Sent %0d numbers and checked %0d divisor counts (%0d odd counts, squares).",
               sent_count, checked_count, square_count);
      $display("Highest count seen: %0d; three idling phases on request and response.",
               highest_count);
      if (error_count == 0 && pending_counts.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
